/* sv/sliding_window_penalty_limiter_macros.svh */
// assertion helpers shared by the limiter rtl
`ifndef SLIDING_WINDOW_PENALTY_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_PENALTY_LIMITER_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define SWPL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, off during reset
`define SWPL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/swpl_pkg.sv */
package swpl_pkg;

   // field widths
   localparam int TIME_W    = 32;
   localparam int POINTS_W  = 16;
   localparam int TOTAL_W   = 20;
   localparam int MAXP_W    = 20;
   localparam int WSEC_W    = 16;
   localparam int WMS_W     = 26;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 1;

   // defaults and constants
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MS_PER_S        = 1000;
   localparam int WINDOW_S_RESET  = 60;
   localparam logic [WMS_W-1:0]  WINDOW_MS_RESET = WMS_W'(WINDOW_S_RESET * MS_PER_S);
   localparam logic [MAXP_W-1:0] MAXP_RESET      = MAXP_W'(100);

   // command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POINTS     = CSR_IDX_W'(1);

   typedef struct packed {
      logic [TIME_W-1:0]   time_ms;
      logic [POINTS_W-1:0] points;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic shift;
      logic finish;
   } seq_ctrl_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXPIRE
   } state_type;

endpackage

/* sv/swpl_cell.sv */
module swpl_cell
   import swpl_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     neighbor_in,
   input  entry_type     new_in,
   output entry_type     entry_out
);

   entry_type entry_ff;
   entry_type entry_in;

   // shift toward the head on expiry, capture a new entry on append
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = neighbor_in;
      end else if (ctrl.load) begin
         entry_in = new_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

/* sv/sliding_window_penalty_limiter.sv */
// add: result strobe in the cycle after the transfer; the next item may follow at once
// query: expired entries are shifted out of the head cell one by one, then the result
//        strobe follows, set by the head cell compare and the shift chain
// busy stays high while a query walks the chain; results cannot be stalled
// reset empties the queue, clears the sum, window 60 s and limit 100 points
`include "sliding_window_penalty_limiter_macros.svh"

module sliding_window_penalty_limiter
   import swpl_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_command,
   input  logic [TIME_W-1:0]    req_now_ms,
   input  logic [POINTS_W-1:0]  req_points,
   output logic                 rsp_valid,
   output logic                 rsp_limit_reached,
   output logic [TOTAL_W-1:0]   rsp_total_points,
   output logic                 rsp_status,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = POINTS_W + CNT_W;
   localparam int CMP_W = (SUM_W > MAXP_W) ? SUM_W : MAXP_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [WMS_W-1:0]   window_ms_ff, window_ms_in;
   logic [MAXP_W-1:0]  max_points_ff, max_points_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_limit_ff, rsp_limit_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               add_accept;
   logic               query_accept;
   logic               full;
   logic               add_ok;
   logic               expired;
   logic [TIME_W-1:0]  age;
   logic [TOTAL_W-1:0] sum_sat;
   seq_ctrl_type       seq;
   entry_type          new_entry;
   entry_type          head;
   entry_type          cell_q [QUEUE_DEPTH];
   cell_ctrl_type      cell_ctrl [QUEUE_DEPTH];

   // input transfer decode
   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign add_accept   = accept && (req_command == CMD_ADD);
   assign query_accept = accept && (req_command == CMD_QUERY);
   assign full         = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign add_ok       = add_accept && !full;
   assign new_entry    = '{time_ms: req_now_ms, points: req_points};

   // chain of entry cells, cell zero is the head
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type neighbor;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign neighbor = cell_q[i];
      end else begin : g_mid
         assign neighbor = cell_q[i+1];
      end
      assign cell_ctrl[i] = '{load: add_ok && (count_ff == CNT_W'(i)), shift: seq.shift};
      swpl_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .neighbor_in (neighbor),
         .new_in      (new_entry),
         .entry_out   (cell_q[i])
      );
   end

   // head age against the window
   assign head    = cell_q[0];
   assign age     = now_ff - head.time_ms;
   assign expired = (count_ff != '0) && (age > TIME_W'(window_ms_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            if (!expired) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      seq = '{shift: 1'b0, finish: 1'b0};
      case (state_ff)
         ST_IDLE: seq = '{shift: 1'b0, finish: 1'b0};
         ST_EXPIRE: begin
            seq.shift  = expired;
            seq.finish = !expired;
         end
         default: seq = '{shift: 1'b0, finish: 1'b0};
      endcase
   end

   // count, sum and query time
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      now_in   = now_ff;
      if (add_ok) begin
         count_in = count_ff + CNT_W'(1);
         sum_in   = sum_ff + SUM_W'(req_points);
      end else if (seq.shift) begin
         count_in = count_ff - CNT_W'(1);
         sum_in   = sum_ff - SUM_W'(head.points);
      end
      if (query_accept) begin
         now_in = req_now_ms;
      end
   end

   // saturate the reported sum
   if (SUM_W > TOTAL_W) begin : g_sat
      assign sum_sat = (sum_in > SUM_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                         : sum_in[TOTAL_W-1:0];
   end else begin : g_nosat
      assign sum_sat = TOTAL_W'(sum_in);
   end

   // result register
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_limit_in  = rsp_limit_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      if (add_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_limit_in  = 1'b0;
         rsp_total_in  = sum_sat;
         rsp_status_in = full;
      end else if (seq.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_limit_in  = (CMP_W'(sum_ff) >= CMP_W'(max_points_ff));
         rsp_total_in  = sum_sat;
         rsp_status_in = 1'b0;
      end
   end

   // configuration writes, window kept in ms
   always_comb begin
      window_ms_in  = window_ms_ff;
      max_points_in = max_points_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_SECONDS: begin
               window_ms_in = WMS_W'(csr_write_data[WSEC_W-1:0]) * WMS_W'(MS_PER_S);
            end
            CSR_MAX_POINTS: max_points_in = csr_write_data[MAXP_W-1:0];
            default: window_ms_in = window_ms_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         sum_ff        <= '0;
         window_ms_ff  <= WINDOW_MS_RESET;
         max_points_ff <= MAXP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         window_ms_ff  <= window_ms_in;
         max_points_ff <= max_points_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      rsp_limit_ff  <= rsp_limit_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_limit_reached = rsp_limit_ff;
   assign rsp_total_points  = rsp_total_ff;
   assign rsp_status        = rsp_status_ff;

   // checks
   `SWPL_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "count overflow")
   `SWPL_ASSERT_NOW(a_empty_sum, count_ff == '0, sum_ff == '0, "empty queue with nonzero sum")
   `SWPL_ASSERT_NEXT(a_refused_add, add_accept && full, $stable(count_ff) && $stable(sum_ff),
                     "refused add changed state")
   `SWPL_ASSERT_NEXT(a_shift_count, seq.shift, count_ff == CNT_W'($past(count_ff) - 1'b1),
                     "expiry did not drop one entry")
   `SWPL_ASSERT_NEXT(a_query_result, seq.finish, rsp_valid && !busy,
                     "query end without result")

endmodule

/* dv/sliding_window_penalty_limiter_tb.sv */
module sliding_window_penalty_limiter_tb
   import swpl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = QUEUE_DEPTH_DEF;

   // one result of the limiter
   typedef struct packed {
      logic               limit_reached;
      logic [TOTAL_W-1:0] total_points;
      logic               status;
   } limiter_verdict_type;

   // one line of the directed plan; a golden verdict is used where armed
   typedef struct packed {
      logic                command;
      logic [TIME_W-1:0]   now_ms;
      logic [POINTS_W-1:0] points;
      logic [4:0]          reps;
      logic                armed;
      limiter_verdict_type golden;
   } plan_row_type;

   localparam int PLAN_ROWS = 13;

   // reset settings: window 60000 ms, limit 100 points
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // query on an empty queue
      '{CMD_QUERY, 32'd0,          16'd0,      5'd1,  1'b1, '{1'b0, 20'd0,       1'b0}},
      // zero points still take a slot
      '{CMD_ADD,   32'd1000,       16'd0,      5'd1,  1'b1, '{1'b0, 20'd0,       1'b0}},
      '{CMD_ADD,   32'd1000,       16'hFFFF,   5'd1,  1'b1, '{1'b0, 20'd65535,   1'b0}},
      // age equal to the window keeps the entries
      '{CMD_QUERY, 32'd61000,      16'd0,      5'd1,  1'b1, '{1'b1, 20'd65535,   1'b0}},
      // one ms more expires both
      '{CMD_QUERY, 32'd61001,      16'd0,      5'd1,  1'b1, '{1'b0, 20'd0,       1'b0}},
      // time counter wrap
      '{CMD_ADD,   32'hFFFF_FFFF,  16'd100,    5'd1,  1'b1, '{1'b0, 20'd100,     1'b0}},
      '{CMD_QUERY, 32'd59999,      16'd0,      5'd1,  1'b1, '{1'b1, 20'd100,     1'b0}},
      '{CMD_QUERY, 32'd60000,      16'd0,      5'd1,  1'b1, '{1'b0, 20'd0,       1'b0}},
      // fill the queue with maximum points
      '{CMD_ADD,   32'd5,          16'hFFFF,   5'd16, 1'b0, '{1'b0, 20'd0,       1'b0}},
      // add on a full queue is refused
      '{CMD_ADD,   32'd6,          16'd1,      5'd1,  1'b1, '{1'b0, 20'd1048560, 1'b1}},
      '{CMD_QUERY, 32'd60005,      16'd0,      5'd1,  1'b1, '{1'b1, 20'd1048560, 1'b0}},
      // the whole queue expires in one query
      '{CMD_QUERY, 32'd60006,      16'd0,      5'd1,  1'b1, '{1'b0, 20'd0,       1'b0}},
      // points are ignored on a query
      '{CMD_QUERY, 32'd70000,      16'hFFFF,   5'd1,  1'b1, '{1'b0, 20'd0,       1'b0}}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_command = CMD_ADD;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic [POINTS_W-1:0]  req_points = '0;
   logic                 rsp_valid;
   logic                 rsp_limit_reached;
   logic [TOTAL_W-1:0]   rsp_total_points;
   logic                 rsp_status;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW_SECONDS;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // golden verdict that travels with the item on the request side
   logic                 golden_armed = 1'b0;
   limiter_verdict_type  golden_verdict = '0;

   // shadow of the limiter state
   logic [TIME_W-1:0]    shadow_time [DEPTH];
   logic [POINTS_W-1:0]  shadow_points [DEPTH];
   int unsigned          shadow_head = 0;
   int unsigned          shadow_tail = 0;
   int unsigned          shadow_held = 0;
   logic [31:0]          shadow_sum = '0;
   logic [WSEC_W-1:0]    window_s = WSEC_W'(WINDOW_S_RESET);
   logic [MAXP_W-1:0]    max_pts = MAXP_RESET;

   limiter_verdict_type  verdict_queue [$];
   int unsigned          mismatch_count = 0;
   bit                   steady = 1'b0;
   logic [TIME_W-1:0]    sim_ms;

   sliding_window_penalty_limiter #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_now_ms        (req_now_ms),
      .req_points        (req_points),
      .rsp_valid         (rsp_valid),
      .rsp_limit_reached (rsp_limit_reached),
      .rsp_total_points  (rsp_total_points),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // advance the shadow state by one item and return what the limiter should report
   function automatic limiter_verdict_type penalty_window_step(input logic cmd,
                                                               input logic [TIME_W-1:0] now,
                                                               input logic [POINTS_W-1:0] pts);
      limiter_verdict_type v;
      logic [31:0]         window_ms;
      logic [31:0]         age;
      v = '0;
      if (cmd == CMD_ADD) begin
         if (shadow_held >= DEPTH) begin
            v.status = 1'b1;
         end else begin
            shadow_time[shadow_tail] = now;
            shadow_points[shadow_tail] = pts;
            shadow_tail = (shadow_tail + 1) % DEPTH;
            shadow_held++;
            shadow_sum = shadow_sum + 32'(pts);
         end
      end else begin
         window_ms = 32'(window_s) * 32'(MS_PER_S);
         // drop expired entries from the head, stop at the first live one
         while (shadow_held != 0) begin
            age = now - shadow_time[shadow_head];
            if (age <= window_ms) break;
            shadow_sum = shadow_sum - 32'(shadow_points[shadow_head]);
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_held--;
         end
         v.limit_reached = (shadow_sum >= 32'(max_pts));
      end
      v.total_points = (shadow_sum > 32'hFFFFF) ? 20'hFFFFF : shadow_sum[TOTAL_W-1:0];
      return v;
   endfunction

   // results, accepted items and register writes, all seen at the rising edge
   always @(posedge clock) begin
      limiter_verdict_type want;
      limiter_verdict_type step_verdict;
      if (reset) begin
         shadow_head = 0;
         shadow_tail = 0;
         shadow_held = 0;
         shadow_sum = '0;
         window_s = WSEC_W'(WINDOW_S_RESET);
         max_pts = MAXP_RESET;
      end else begin
         // result transfer
         if (rsp_valid) begin
            if (verdict_queue.size() == 0) begin
               $error("result with nothing expected: limit_reached %0d total_points %0d status %0d",
                      rsp_limit_reached, rsp_total_points, rsp_status);
               mismatch_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_limit_reached !== want.limit_reached) begin
                  $error("limit_reached: expected %0d, got %0d",
                         want.limit_reached, rsp_limit_reached);
                  mismatch_count++;
               end
               if (rsp_total_points !== want.total_points) begin
                  $error("total_points: expected %0d, got %0d",
                         want.total_points, rsp_total_points);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         // item transfer
         if (start && !busy) begin
            step_verdict = penalty_window_step(req_command, req_now_ms, req_points);
            verdict_queue.push_back(golden_armed ? golden_verdict : step_verdict);
         end
         // register write
         if (csr_write_enable) begin
            if (csr_index == CSR_WINDOW_SECONDS) window_s = csr_write_data[WSEC_W-1:0];
            else if (csr_index == CSR_MAX_POINTS) max_pts = csr_write_data[MAXP_W-1:0];
         end
      end
   end

   // mostly back to back, sometimes short gaps, now and then a long one
   function automatic int unsigned sender_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // present one item and hold it until the transfer, then maybe pause
   task automatic send_item(input logic cmd, input logic [TIME_W-1:0] now,
                            input logic [POINTS_W-1:0] pts, input logic armed,
                            input limiter_verdict_type golden);
      int unsigned gap;
      start <= 1'b1;
      req_command <= cmd;
      req_now_ms <= now;
      req_points <= pts;
      golden_armed <= armed;
      golden_verdict <= golden;
      do @(posedge clock); while (busy);
      gap = sender_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding result arrive
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (verdict_queue.size() != 0 || busy);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   // both registers, back to back
   task automatic write_settings(input logic [CSR_W-1:0] window_data,
                                 input logic [CSR_W-1:0] max_data);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_WINDOW_SECONDS;
      csr_write_data <= window_data;
      @(posedge clock);
      csr_index <= CSR_MAX_POINTS;
      csr_write_data <= max_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // one setting, then random adds and queries on a clock that moves at window scale
   task automatic run_phase(input logic [CSR_W-1:0] window_data, input logic [CSR_W-1:0] max_data,
                            input int unsigned add_pct, input int unsigned count);
      int unsigned         step_max;
      logic                cmd;
      logic [TIME_W-1:0]   now;
      logic [POINTS_W-1:0] pts;
      int unsigned         r;
      wait_quiet();
      write_settings(window_data, max_data);
      step_max = (32'(window_data[WSEC_W-1:0]) * MS_PER_S) / 4 + 4;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 20 == 0) steady = ($urandom_range(0, 3) == 0);
         cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_QUERY;
         sim_ms = sim_ms + $urandom_range(0, step_max);
         // an out-of-order timestamp now and then
         now = ($urandom_range(0, 19) == 0) ? $urandom() : sim_ms;
         r = $urandom_range(0, 9);
         if (r == 0) pts = '0;
         else if (r == 1) pts = '1;
         else if (r < 5) pts = POINTS_W'($urandom_range(0, 255));
         else pts = POINTS_W'($urandom_range(0, 65535));
         send_item(cmd, now, pts, 1'b0, '0);
      end
   endtask

   initial begin
      plan_row_type row;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed plan at the reset settings
      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         for (int k = 0; k < row.reps; k++) begin
            send_item(row.command, row.now_ms, row.points, row.armed, row.golden);
         end
      end

      // random phases through the register extremes
      sim_ms = $urandom();
      run_phase(20'd1, 20'd50000, 60, 80);
      run_phase(20'd0, 20'd0, 55, 60);
      run_phase(20'd65535, 20'hFFFFF, 75, 80);
      run_phase(20'hF0002, CSR_W'($urandom_range(0, 20'hFFFFF)), 50, 90);
      run_phase(CSR_W'($urandom_range(0, 20'hFFFFF)), CSR_W'($urandom_range(0, 20'hFFFFF)),
                60, 90);

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/swpl_pkg.sv
sv/swpl_cell.sv
sv/sliding_window_penalty_limiter.sv
dv/sliding_window_penalty_limiter_tb.sv
